FILE: sv/fcsw_pkg.sv
package fcsw_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int SAMPLE_WIDTH = 24;
  localparam int CH_W = 2;

  // function codes
  localparam logic [1:0] FUNC_TARE    = 2'd0;
  localparam logic [1:0] FUNC_SPAN    = 2'd1;
  localparam logic [1:0] FUNC_MEASURE = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_TARE_DONE = 3'd0;
  localparam logic [2:0] KIND_CAL_OK    = 3'd1;
  localparam logic [2:0] KIND_CAL_FAIL  = 3'd2;
  localparam logic [2:0] KIND_WEIGHT    = 3'd3;
  localparam logic [2:0] KIND_RAW       = 3'd4;

  // register indexes
  localparam logic [1:0] REG_CAL_WEIGHT = 2'd0;
  localparam logic [1:0] REG_SAMPLES    = 2'd1;
  localparam logic [1:0] REG_MIN_DEFL   = 2'd2;

  // phases
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_TARE      = 2'd1;
  localparam logic [1:0] PH_TARE_DONE = 2'd2;
  localparam logic [1:0] PH_SPAN      = 2'd3;

  localparam int SUM_W = 33;   // sums of up to 255 samples, with margin
  localparam int TOT_W = 36;
  localparam int NUM_W = 40;   // weighted deflection sum
  localparam int MAG_W = 64;   // dividend width
  localparam int DIV_CNT_W = 7;

  typedef struct packed {
    logic [1:0]                     func;
    logic [1:0]                     channel;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [2:0]                     kind;
    logic signed [31:0]             weight_tenths;
    logic signed [SAMPLE_WIDTH-1:0] raw_value;
    logic [1:0]                     raw_channel;
  } out_word_t;

  typedef struct packed {
    logic            start;
    logic [MAG_W-1:0] dividend;
    logic [TOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
    logic [TOT_W:0]   remainder;
  } div_rsp_t;

endpackage

FILE: sv/fcsw_divider.sv
module fcsw_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  fcsw_pkg::div_req_t  req,
  output fcsw_pkg::div_rsp_t  rsp
);

  logic [fcsw_pkg::MAG_W-1:0]     q_r, q_nxt;
  logic [fcsw_pkg::TOT_W:0]       rem_r, rem_nxt;
  logic [fcsw_pkg::TOT_W-1:0]     dvs_r, dvs_nxt;
  logic [fcsw_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt, done_r, done_nxt;
  logic [fcsw_pkg::TOT_W+1:0]     trial;
  logic [fcsw_pkg::TOT_W:0]       shifted;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted  = {rem_r[fcsw_pkg::TOT_W-1:0], q_r[fcsw_pkg::MAG_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dvs_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[fcsw_pkg::TOT_W+1]) begin
        rem_nxt = trial[fcsw_pkg::TOT_W:0];
        q_nxt   = {q_r[fcsw_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[fcsw_pkg::MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == fcsw_pkg::DIV_CNT_W'(fcsw_pkg::MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = q_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: sv/four_cell_scale_calibrate_weigh.sv
// Four-cell scale tare, span calibration and weighing. One word is taken at a
// time; in_stall is high from acceptance until the result (if any) has been
// taken. The span close-out walks the four channels one per cycle. A weight
// word on the last channel, once calibrated, accumulates the channel
// deflections in turn, forms the product, loads and starts the serial divider,
// which produces the quotient bit by bit, and then rounds the quotient.
// Registers: 0 cal_weight_grams, 1 samples_per_channel, 2 min_total_deflection
// at byte addresses 0, 4, 8.
module four_cell_scale_calibrate_weigh (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fcsw_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fcsw_pkg::out_word_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int NC = fcsw_pkg::NUM_CHANNELS;
  localparam int SW = fcsw_pkg::SAMPLE_WIDTH;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SPAN  = 3'd1;
  localparam logic [2:0] ST_ACC   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_ROUND = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // configuration registers
  logic [15:0] cal_w_r;
  logic [7:0]  spc_r;
  logic [25:0] min_defl_r;
  logic        wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_w_r    <= 16'd3000;
      spc_r      <= 8'd5;
      min_defl_r <= 26'd10000;
    end else if (wr) begin
      unique case (cfg_paddr[3:2])
        fcsw_pkg::REG_CAL_WEIGHT: cal_w_r    <= cfg_pwdata[15:0];
        fcsw_pkg::REG_SAMPLES:    spc_r      <= cfg_pwdata[7:0];
        fcsw_pkg::REG_MIN_DEFL:   min_defl_r <= cfg_pwdata[25:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      fcsw_pkg::REG_CAL_WEIGHT: cfg_prdata = {16'd0, cal_w_r};
      fcsw_pkg::REG_SAMPLES:    cfg_prdata = {24'd0, spc_r};
      fcsw_pkg::REG_MIN_DEFL:   cfg_prdata = {6'd0, min_defl_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  // block state
  logic [2:0]  st_r;
  logic [1:0]  phase_r;
  logic        calibrated_r;
  logic [7:0]  cal_n_r;
  logic [7:0]  cnt_r [NC];
  logic signed [fcsw_pkg::SUM_W-1:0] zsum_r [NC];
  logic signed [fcsw_pkg::SUM_W-1:0] ssum_r [NC];
  logic signed [SW-1:0] latest_r [NC];
  logic        pol_neg_r [NC];
  logic [fcsw_pkg::TOT_W-1:0] total_r;
  logic [1:0]  idx_r;
  logic signed [fcsw_pkg::NUM_W-1:0] num_r;
  logic        neg_r;
  logic [fcsw_pkg::MAG_W-1:0] mag_r;
  logic        ovalid_r;
  fcsw_pkg::out_word_t odata_r;

  fcsw_pkg::div_req_t dreq;
  fcsw_pkg::div_rsp_t drsp;

  fcsw_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic accept;
  assign in_stall = (st_r != ST_IDLE) || ovalid_r;
  assign accept   = in_valid && !in_stall;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  // shared datapath values
  logic signed [fcsw_pkg::SUM_W-1:0] dlt;
  logic signed [SW+8:0] nlat;
  logic signed [fcsw_pkg::NUM_W-1:0] dw;
  logic [fcsw_pkg::TOT_W-1:0] absd;
  logic [fcsw_pkg::TOT_W:0]   rem2;
  logic [fcsw_pkg::MAG_W-1:0] q_rnd;
  logic [fcsw_pkg::TOT_W-1:0] thresh;
  logic [19:0] w10;
  logic [fcsw_pkg::NUM_W+19:0] prod_u;
  logic [fcsw_pkg::NUM_W-1:0] amag;
  logic [7:0] cnt_inc;
  logic       full_after;

  always_comb begin
    dlt  = ssum_r[idx_r] - zsum_r[idx_r];
    absd = dlt[fcsw_pkg::SUM_W-1] ? fcsw_pkg::TOT_W'(-dlt) : fcsw_pkg::TOT_W'(dlt);
    nlat = $signed({1'b0, cal_n_r}) * latest_r[idx_r];
    dw   = fcsw_pkg::NUM_W'(nlat) - fcsw_pkg::NUM_W'(zsum_r[idx_r]);
    rem2 = {drsp.remainder[fcsw_pkg::TOT_W-1:0], 1'b0};
    q_rnd = drsp.quotient +
            fcsw_pkg::MAG_W'(rem2 >= {1'b0, total_r});
    thresh = fcsw_pkg::TOT_W'(min_defl_r) * fcsw_pkg::TOT_W'(cal_n_r);
    amag = num_r[fcsw_pkg::NUM_W-1] ? fcsw_pkg::NUM_W'(-num_r) : fcsw_pkg::NUM_W'(num_r);
    // ten times the weight in grams, then the deflection product
    w10    = {1'b0, cal_w_r, 3'd0} + {3'd0, cal_w_r, 1'b0};
    prod_u = amag * w10;
  end

  // collection helper: count for the item's channel after this word
  logic [7:0] eff_n;
  logic       restart;
  always_comb begin
    restart = (in_data.func == fcsw_pkg::FUNC_TARE && phase_r != fcsw_pkg::PH_TARE) ||
              (in_data.func == fcsw_pkg::FUNC_SPAN && phase_r == fcsw_pkg::PH_TARE_DONE);
    eff_n = (in_data.func == fcsw_pkg::FUNC_TARE && restart) ?
            ((spc_r == 8'd0) ? 8'd1 : spc_r) : cal_n_r;
    full_after = 1'b1;
    for (int c = 0; c < NC; c++) begin
      cnt_inc = restart ? 8'd0 : cnt_r[c];
      if (c == int'(in_data.channel) && cnt_inc < eff_n) cnt_inc = cnt_inc + 8'd1;
      if (cnt_inc < eff_n) full_after = 1'b0;
    end
  end

  // result word as set up at acceptance
  fcsw_pkg::out_word_t idle_word;
  always_comb begin
    idle_word = '0;
    idle_word.raw_channel = in_data.channel;
    if (in_data.func == fcsw_pkg::FUNC_MEASURE) begin
      idle_word.kind = fcsw_pkg::KIND_RAW;
      if (!calibrated_r) idle_word.raw_value = in_data.sample;
    end else begin
      idle_word.kind = fcsw_pkg::KIND_TARE_DONE;
    end
  end

  always_ff @(posedge clk) begin
    dreq.start <= (st_r == ST_DIV);
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      phase_r      <= fcsw_pkg::PH_IDLE;
      calibrated_r <= 1'b0;
      cal_n_r      <= '0;
      ovalid_r     <= 1'b0;
      total_r      <= '0;
      for (int c = 0; c < NC; c++) begin
        cnt_r[c]     <= '0;
        zsum_r[c]    <= '0;
        ssum_r[c]    <= '0;
        latest_r[c]  <= '0;
        pol_neg_r[c] <= 1'b0;
      end
    end else begin
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (accept) begin
          odata_r <= idle_word;
          priority if (in_data.func == fcsw_pkg::FUNC_TARE) begin
            if (restart) begin
              calibrated_r <= 1'b0;
              cal_n_r <= eff_n;
              phase_r <= fcsw_pkg::PH_TARE;
            end
            for (int c = 0; c < NC; c++) begin
              logic [7:0] cc;
              cc = restart ? 8'd0 : cnt_r[c];
              if (c == int'(in_data.channel) && cc < eff_n) begin
                cnt_r[c]  <= cc + 8'd1;
                zsum_r[c] <= (restart ? '0 : zsum_r[c]) +
                             fcsw_pkg::SUM_W'(in_data.sample);
              end else begin
                cnt_r[c] <= cc;
                if (restart) zsum_r[c] <= '0;
              end
            end
            if (full_after) begin
              phase_r <= fcsw_pkg::PH_TARE_DONE;
              ovalid_r <= 1'b1;
            end
          end else if (in_data.func == fcsw_pkg::FUNC_SPAN) begin
            if (phase_r == fcsw_pkg::PH_TARE_DONE || phase_r == fcsw_pkg::PH_SPAN) begin
              if (restart) phase_r <= fcsw_pkg::PH_SPAN;
              for (int c = 0; c < NC; c++) begin
                logic [7:0] cc;
                cc = restart ? 8'd0 : cnt_r[c];
                if (c == int'(in_data.channel) && cc < eff_n) begin
                  cnt_r[c]  <= cc + 8'd1;
                  ssum_r[c] <= (restart ? '0 : ssum_r[c]) +
                               fcsw_pkg::SUM_W'(in_data.sample);
                end else begin
                  cnt_r[c] <= cc;
                  if (restart) ssum_r[c] <= '0;
                end
              end
              if (full_after) begin
                idx_r   <= '0;
                total_r <= '0;
                st_r    <= ST_SPAN;
              end
            end
          end else if (in_data.func == fcsw_pkg::FUNC_MEASURE) begin
            latest_r[in_data.channel] <= in_data.sample;
            if (!calibrated_r) begin
              ovalid_r <= 1'b1;
            end else if (in_data.channel == 2'(NC - 1)) begin
              idx_r <= '0;
              num_r <= '0;
              st_r  <= ST_ACC;
            end
          end else begin
          end
        end
        // span close-out: one channel per cycle
        ST_SPAN: begin
          pol_neg_r[idx_r] <= dlt[fcsw_pkg::SUM_W-1];
          total_r <= total_r + absd;
          idx_r <= idx_r + 2'd1;
          if (idx_r == 2'(NC - 1)) st_r <= ST_OUT;
        end
        // weighted deflection accumulation
        ST_ACC: begin
          num_r <= pol_neg_r[idx_r] ? num_r - dw : num_r + dw;
          idx_r <= idx_r + 2'd1;
          if (idx_r == 2'(NC - 1)) st_r <= ST_MUL;
        end
        ST_MUL: begin
          neg_r <= num_r[fcsw_pkg::NUM_W-1] && (cal_w_r != 16'd0);
          mag_r <= fcsw_pkg::MAG_W'(prod_u);
          if (total_r == '0) begin
            odata_r.kind <= fcsw_pkg::KIND_WEIGHT;
            ovalid_r <= 1'b1;
            st_r <= ST_IDLE;
          end else begin
            st_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          dreq.dividend <= mag_r;
          dreq.divisor  <= total_r;
          st_r <= ST_ROUND;
        end
        ST_ROUND: if (drsp.done) begin
          odata_r.kind <= fcsw_pkg::KIND_WEIGHT;
          if (neg_r)
            odata_r.weight_tenths <= (q_rnd >= 64'h8000_0000) ? 32'sh8000_0000 :
                                     -$signed(q_rnd[31:0]);
          else
            odata_r.weight_tenths <= (q_rnd > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF :
                                     $signed(q_rnd[31:0]);
          ovalid_r <= 1'b1;
          st_r <= ST_IDLE;
        end
        ST_OUT: begin
          phase_r <= fcsw_pkg::PH_IDLE;
          if (total_r == '0 || total_r < thresh) begin
            calibrated_r <= 1'b0;
            odata_r.kind <= fcsw_pkg::KIND_CAL_FAIL;
          end else begin
            calibrated_r <= 1'b1;
            odata_r.kind <= fcsw_pkg::KIND_CAL_OK;
          end
          ovalid_r <= 1'b1;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a result never appears while a weight computation is still dividing
  a_no_out_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV || st_r == ST_ROUND) |-> !ovalid_r)
    else $error("result raised during division");
  // divider completion only while waiting for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> st_r == ST_ROUND)
    else $error("divider finished outside wait state");
  // the block is closed to input whenever it is working
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> in_stall)
    else $error("input open while busy");
`endif

endmodule
